### rtl/sacl_pkg.sv
package sacl_pkg;

  localparam int MAX_SETS_D    = 256;
  localparam int MAX_WAYS_D    = 8;
  localparam int ADDR_WIDTH_D  = 32;
  localparam int COUNT_WIDTH_D = 16;

  localparam logic [1:0] REG_CACHE = 2'd0;
  localparam logic [1:0] REG_ASSOC = 2'd1;
  localparam logic [1:0] REG_BLOCK = 2'd2;

  localparam logic [4:0] CACHE_RST = 5'd12;
  localparam logic [1:0] ASSOC_RST = 2'd2;
  localparam logic [3:0] BLOCK_RST = 4'd5;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_WRITE
  } back_state_t;

endpackage

### rtl/sacl_front.sv
module sacl_front import sacl_pkg::*; #(
  parameter int MAX_SETS   = MAX_SETS_D,
  parameter int ADDR_WIDTH = ADDR_WIDTH_D,
  parameter int SET_W      = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        q_full,
  input  logic        op,
  input  logic [31:0] address,
  input  logic [4:0]  cache_bits,
  input  logic [1:0]  assoc_bits,
  input  logic [3:0]  block_bits,
  output logic        q_push,
  output logic        q_op,
  output logic [SET_W-1:0] q_set,
  output logic [63:0] q_tag
);

  localparam int LIM = (MAX_SETS > 1) ? $clog2(MAX_SETS + 1) - 1 : 0;

  logic [6:0]  idx_raw;
  logic [5:0]  idx_bits;
  logic [63:0] addr;
  logic [63:0] shifted;

  always_comb begin
    addr = '0;
    for (int i = 0; i < 32; i++) begin
      if (i < ADDR_WIDTH) addr[i] = address[i];
    end
    idx_raw = {2'b0, cache_bits} - {3'b0, block_bits} - {5'b0, assoc_bits};
    if (idx_raw[6]) idx_bits = '0;
    else if (idx_raw > 7'(LIM)) idx_bits = 6'(LIM);
    else idx_bits = idx_raw[5:0];
    shifted = addr >> block_bits;
  end

  always_ff @(posedge clk) begin
    q_op  <= op;
    q_set <= SET_W'(shifted & ((64'd1 << idx_bits) - 64'd1));
    q_tag <= shifted >> idx_bits;
  end

  always_ff @(posedge clk) begin
    if (rst) q_push <= 1'b0;
    else q_push <= start && !q_full;
  end

endmodule

### rtl/sacl_back.sv
module sacl_back import sacl_pkg::*; #(
  parameter int MAX_SETS    = MAX_SETS_D,
  parameter int MAX_WAYS    = MAX_WAYS_D,
  parameter int COUNT_WIDTH = COUNT_WIDTH_D,
  parameter int SET_W       = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1,
  parameter int WAY_W       = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic        in_op,
  input  logic [SET_W-1:0] in_set,
  input  logic [63:0] in_tag,
  input  logic [1:0]  assoc_bits,
  output logic        busy,
  output logic        done,
  output logic        hit,
  output logic        write_back,
  output logic [2:0]  way
);

  localparam int ROW_W = 64 + 1 + 1 + COUNT_WIDTH;

  back_state_t state, state_next;
  logic [ROW_W*MAX_WAYS-1:0] mem [MAX_SETS];
  logic [MAX_SETS-1:0] row_valid;
  logic [ROW_W*MAX_WAYS-1:0] rd_row, row_new;
  logic        rv;
  logic        op_r;
  logic [SET_W-1:0] set_r;
  logic [63:0] tag_r;

  logic [63:0] e_tag [MAX_WAYS];
  logic        e_v [MAX_WAYS];
  logic        e_d [MAX_WAYS];
  logic [COUNT_WIDTH-1:0] e_c [MAX_WAYS];
  logic [3:0]  nways;
  logic        f_hit, f_inv;
  logic [WAY_W-1:0] hw, iw, lw, vw;
  logic [COUNT_WIDTH-1:0] best;
  logic        wb;

  always_comb begin
    nways = (MAX_WAYS < 16 && (5'd1 << assoc_bits) > 5'(MAX_WAYS))
            ? 4'(MAX_WAYS) : 4'(5'd1 << assoc_bits);
    for (int w = 0; w < MAX_WAYS; w++) begin
      {e_tag[w], e_v[w], e_d[w], e_c[w]} = rd_row[w*ROW_W +: ROW_W];
      if (!rv) e_v[w] = 1'b0;
      if (!rv) e_d[w] = 1'b0;
      if (!rv) e_c[w] = '0;
      if (!rv) e_tag[w] = '0;
    end
    f_hit = 1'b0; hw = '0;
    f_inv = 1'b0; iw = '0;
    lw = '0; best = e_c[0];
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (w < 32'(nways)) begin
        if (e_v[w] && e_tag[w] == tag_r) begin f_hit = 1'b1; hw = WAY_W'(w); end
        if (!e_v[w]) begin f_inv = 1'b1; iw = WAY_W'(w); end
      end
    end
    for (int w = 1; w < MAX_WAYS; w++) begin
      if (w < 32'(nways) && e_c[w] < best) begin best = e_c[w]; lw = WAY_W'(w); end
    end
    vw = f_inv ? iw : lw;
    wb = !f_hit && e_v[vw] && e_d[vw];
    row_new = rd_row;
    if (!rv) row_new = '0;
    if (f_hit) begin
      row_new[hw*ROW_W +: ROW_W] = {e_tag[hw], 1'b1, e_d[hw] | op_r,
        (&e_c[hw]) ? e_c[hw] : e_c[hw] + 1'b1};
    end else begin
      row_new[vw*ROW_W +: ROW_W] = {tag_r, 1'b1, op_r, {COUNT_WIDTH{1'b0}}};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      op_r  <= in_op;
      set_r <= in_set;
      tag_r <= in_tag;
    end
    if (state == ST_READ) rd_row <= mem[set_r];
    if (state == ST_WRITE) mem[set_r] <= row_new;
    if (state == ST_WRITE) begin
      hit        <= f_hit;
      write_back <= wb;
      way        <= 3'(f_hit ? hw : vw);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      row_valid <= '0;
      rv <= 1'b0;
      done <= 1'b0;
    end else begin
      state <= state_next;
      done  <= state == ST_WRITE;
      if (state == ST_READ) rv <= row_valid[set_r];
      if (state == ST_WRITE) row_valid[set_r] <= 1'b1;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (push) state_next = ST_READ;
      ST_READ:  state_next = ST_WRITE;
      ST_WRITE: state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy = state != ST_IDLE;
  end

endmodule

### rtl/set_assoc_cache_lfu.sv
// start to done passes through classify, row read, update and result, in that order
// one word at a time; busy holds off start while a word is in flight
// the set row memory has one read and one write port, read-modify-write per access
// reset: synchronous, clears all row valid bits at once and restores size defaults
// results are strobed by done for one cycle; the receiver cannot stall
module set_assoc_cache_lfu import sacl_pkg::*; #(
  parameter int MAX_SETS    = MAX_SETS_D,
  parameter int MAX_WAYS    = MAX_WAYS_D,
  parameter int ADDR_WIDTH  = ADDR_WIDTH_D,
  parameter int COUNT_WIDTH = COUNT_WIDTH_D
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        op,
  input  logic [31:0] address,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [4:0]  cfg_data,
  output logic        done,
  output logic        hit,
  output logic        write_back,
  output logic [2:0]  way
);

  localparam int SET_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;

  logic [4:0] cache_bits;
  logic [1:0] assoc_bits;
  logic [3:0] block_bits;
  logic       q_push, q_op, back_busy;
  logic [SET_W-1:0] q_set;
  logic [63:0] q_tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      cache_bits <= CACHE_RST;
      assoc_bits <= ASSOC_RST;
      block_bits <= BLOCK_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CACHE: cache_bits <= cfg_data;
        REG_ASSOC: assoc_bits <= cfg_data[1:0];
        REG_BLOCK: block_bits <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  assign busy = q_push || back_busy;

  sacl_front #(.MAX_SETS(MAX_SETS), .ADDR_WIDTH(ADDR_WIDTH), .SET_W(SET_W)) u_front (
    .clk, .rst, .start, .q_full(busy), .op, .address,
    .cache_bits, .assoc_bits, .block_bits,
    .q_push, .q_op, .q_set, .q_tag
  );

  sacl_back #(.MAX_SETS(MAX_SETS), .MAX_WAYS(MAX_WAYS), .COUNT_WIDTH(COUNT_WIDTH),
              .SET_W(SET_W)) u_back (
    .clk, .rst, .push(q_push), .in_op(q_op), .in_set(q_set), .in_tag(q_tag),
    .assoc_bits, .busy(back_busy), .done, .hit, .write_back, .way
  );

endmodule
